@@ rtl/i2c_master_byte_engine_defines.svh @@
// ----------------------------------------------------------------------------
// i2c master byte engine assertion macros
// shared concurrent assertion helpers for the rtl files
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define I2CM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cm assertion failed");

// antecedent implies consequent in the next cycle
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2cm assertion failed");

// condition holds every cycle
`define I2CM_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("i2cm assertion failed");

`else

`define I2CM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons)
`define I2CM_ASSERT_ALWAYS(label, clk, rst, cond)

`endif

`endif

@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2c master byte engine package
// command codes, sequencer states, phase indexes and the request/result types
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // request action codes
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_RELEASE = 3'd1;
   localparam logic [2:0] ACT_START   = 3'd2;
   localparam logic [2:0] ACT_STOP    = 3'd3;
   localparam logic [2:0] ACT_WRITE   = 3'd4;
   localparam logic [2:0] ACT_READ    = 3'd5;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_RELEASE = 6'b000010,
      ST_START   = 6'b000100,
      ST_STOP    = 6'b001000,
      ST_WRITE   = 6'b010000,
      ST_READ    = 6'b100000
   } state_type;

   // phase indexes
   localparam logic [4:0] LAST_RELEASE = 5'd1;
   localparam logic [4:0] LAST_START   = 5'd1;
   localparam logic [4:0] LAST_STOP    = 5'd2;
   localparam logic [4:0] WR_BIT_END   = 5'd24;
   localparam logic [4:0] WR_ACK_SCL   = 5'd25;
   localparam logic [4:0] WR_ACK_FALL  = 5'd26;
   localparam logic [4:0] LAST_WRITE   = 5'd27;
   localparam logic [4:0] RD_BIT_BEGIN = 5'd2;
   localparam logic [4:0] RD_BIT_END   = 5'd18;
   localparam logic [4:0] RD_ACK_SCL   = 5'd19;
   localparam logic [4:0] RD_ACK_FALL  = 5'd20;
   localparam logic [4:0] LAST_READ    = 5'd21;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd3;

   // classified tick from front to back
   typedef struct packed {
      state_type  cmd;
      logic [7:0] write_data;
      logic       send_ack;
      logic       sda_in;
   } tick_type;

   // result of one tick
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       nack;
   } rsp_type;

endpackage

@@ rtl/i2cm_fifo.sv @@
// ----------------------------------------------------------------------------
// i2cm fifo
// small register queue that decouples two sides of the engine
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_defines.svh"

module i2cm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             wr, rd;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign wr      = wr_en && !full;
   assign rd      = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (wr && !rd) begin
         count_in = count_ff + CW'(1);
      end else if (rd && !wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `I2CM_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL_CNT)
   `I2CM_ASSERT_NEXT(a_count_hold, clock, reset, wr == rd, $stable(count_ff))
   `I2CM_ASSERT_IMPLY(a_ptr_sync, clock, reset, empty || full, wr_ptr_ff == rd_ptr_ff)

endmodule

@@ rtl/i2cm_front.sv @@
// ----------------------------------------------------------------------------
// i2cm front
// classifies each incoming tick into the sequencer state it would start
// ----------------------------------------------------------------------------
module i2cm_front
   import i2cm_pkg::*;
(
   input  logic [2:0] action,
   input  logic [7:0] write_data,
   input  logic       send_ack,
   input  logic       sda_in,
   output tick_type   tick
);

   always_comb begin
      tick.write_data = write_data;
      tick.send_ack   = send_ack;
      tick.sda_in     = sda_in;
      unique case (action)
         ACT_RELEASE: tick.cmd = ST_RELEASE;
         ACT_START:   tick.cmd = ST_START;
         ACT_STOP:    tick.cmd = ST_STOP;
         ACT_WRITE:   tick.cmd = ST_WRITE;
         ACT_READ:    tick.cmd = ST_READ;
         // no command and unknown codes leave the engine idle
         default:     tick.cmd = ST_IDLE;
      endcase
   end

endmodule

@@ rtl/i2cm_back.sv @@
// ----------------------------------------------------------------------------
// i2cm back
// phase sequencer that drives scl and sda and produces one result per tick
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_defines.svh"

module i2cm_back
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        step,
   input  tick_type    tick,
   output rsp_type     rsp
);

   localparam logic [1:0] K_DATA = 2'd0;
   localparam logic [1:0] K_RISE = 2'd1;
   localparam logic [1:0] K_FALL = 2'd2;

   state_type   state_ff, state_in;
   logic [4:0]  phase_ff, phase_in;
   logic [15:0] hold_ff, hold_in;
   logic [1:0]  k_ff, k_in;
   logic        scl_out_ff, scl_out_in;
   logic        sda_out_ff, sda_out_in;
   logic [7:0]  shift_ff, shift_in;
   logic        ack_ff, ack_in;
   logic        nack_ff, nack_in;
   logic [7:0]  read_ff, read_in;
   logic [15:0] phase_ticks_ff;
   logic [15:0] limit;
   logic [4:0]  last_phase;
   logic        done;

   assign limit = (phase_ticks_ff == '0) ? 16'd1 : phase_ticks_ff;

   always_comb begin
      unique case (state_ff)
         ST_RELEASE: last_phase = LAST_RELEASE;
         ST_START:   last_phase = LAST_START;
         ST_STOP:    last_phase = LAST_STOP;
         ST_WRITE:   last_phase = LAST_WRITE;
         ST_READ:    last_phase = LAST_READ;
         default:    last_phase = '0;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      hold_in    = hold_ff;
      k_in       = k_ff;
      scl_out_in = scl_out_ff;
      sda_out_in = sda_out_ff;
      shift_in   = shift_ff;
      ack_in     = ack_ff;
      nack_in    = nack_ff;
      read_in    = read_ff;
      done       = 1'b0;
      if (step) begin
         if (state_ff == ST_IDLE) begin
            if (tick.cmd != ST_IDLE) begin
               state_in = tick.cmd;
               phase_in = '0;
               hold_in  = 16'd1;
               k_in     = K_DATA;
               case (tick.cmd)
                  ST_RELEASE: scl_out_in = 1'b1;
                  ST_START:   sda_out_in = 1'b0;
                  ST_STOP:    sda_out_in = 1'b0;
                  ST_WRITE: begin
                     shift_in   = tick.write_data;
                     sda_out_in = tick.write_data[7];
                  end
                  ST_READ: begin
                     shift_in   = '0;
                     ack_in     = tick.send_ack;
                     scl_out_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end else if (hold_ff < limit) begin
            hold_in = hold_ff + 16'd1;
         end else begin
            // sample sda at the end of a sampling phase
            if (state_ff == ST_WRITE && phase_ff == WR_ACK_SCL) begin
               nack_in = tick.sda_in;
            end
            if (state_ff == ST_READ && phase_ff >= RD_BIT_BEGIN && phase_ff < RD_BIT_END
                && !phase_ff[0]) begin
               shift_in = {shift_ff[6:0], tick.sda_in};
            end
            if (phase_ff == last_phase) begin
               if (state_ff == ST_READ) begin
                  read_in = shift_in;
               end
               state_in = ST_IDLE;
               phase_in = '0;
               hold_in  = '0;
               done     = 1'b1;
            end else begin
               phase_in = phase_ff + 5'd1;
               hold_in  = 16'd1;
               k_in     = (k_ff == K_FALL) ? K_DATA : k_ff + 2'd1;
               case (state_ff)
                  ST_RELEASE: sda_out_in = 1'b1;
                  ST_START:   scl_out_in = 1'b0;
                  ST_STOP: begin
                     if (phase_in == LAST_STOP) begin
                        sda_out_in = 1'b1;
                     end else begin
                        scl_out_in = 1'b1;
                     end
                  end
                  ST_WRITE: begin
                     if (phase_in < WR_BIT_END) begin
                        if (k_in == K_DATA) begin
                           sda_out_in = shift_ff[7];
                        end else if (k_in == K_RISE) begin
                           scl_out_in = 1'b1;
                        end else begin
                           scl_out_in = 1'b0;
                           shift_in   = {shift_ff[6:0], 1'b0};
                        end
                     end else if (phase_in == WR_BIT_END) begin
                        sda_out_in = 1'b1;
                     end else if (phase_in == WR_ACK_SCL) begin
                        scl_out_in = 1'b1;
                     end else if (phase_in == WR_ACK_FALL) begin
                        scl_out_in = 1'b0;
                     end else begin
                        sda_out_in = 1'b0;
                     end
                  end
                  ST_READ: begin
                     if (phase_in < RD_BIT_BEGIN) begin
                        sda_out_in = 1'b1;
                     end else if (phase_in < RD_BIT_END) begin
                        scl_out_in = !phase_in[0];
                     end else if (phase_in == RD_BIT_END) begin
                        sda_out_in = !ack_ff;
                     end else if (phase_in == RD_ACK_SCL) begin
                        scl_out_in = 1'b1;
                     end else if (phase_in == RD_ACK_FALL) begin
                        scl_out_in = 1'b0;
                     end else begin
                        sda_out_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_comb begin
      rsp.scl_level = scl_out_in;
      rsp.sda_level = sda_out_in;
      rsp.busy_res  = (state_in != ST_IDLE);
      rsp.done_res  = done;
      rsp.read_byte = read_in;
      rsp.nack      = nack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= '0;
         hold_ff        <= '0;
         k_ff           <= K_DATA;
         scl_out_ff     <= 1'b1;
         sda_out_ff     <= 1'b1;
         shift_ff       <= '0;
         ack_ff         <= 1'b0;
         nack_ff        <= 1'b0;
         read_ff        <= '0;
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         hold_ff    <= hold_in;
         k_ff       <= k_in;
         scl_out_ff <= scl_out_in;
         sda_out_ff <= sda_out_in;
         shift_ff   <= shift_in;
         ack_ff     <= ack_in;
         nack_ff    <= nack_in;
         read_ff    <= read_in;
         if (csr_wr_en) begin
            phase_ticks_ff <= csr_wr_data;
         end
      end
   end

   `I2CM_ASSERT_IMPLY(a_idle_clear, clock, reset, state_ff == ST_IDLE, phase_ff == '0 && hold_ff == '0)
   `I2CM_ASSERT_IMPLY(a_busy_hold, clock, reset, state_ff != ST_IDLE, hold_ff != '0)
   `I2CM_ASSERT_IMPLY(a_phase_bound, clock, reset, state_ff != ST_IDLE, phase_ff <= last_phase)
   `I2CM_ASSERT_NEXT(a_no_step_hold, clock, reset, !step, $stable(state_ff) && $stable(hold_ff))

endmodule

@@ rtl/i2c_master_byte_engine.sv @@
// ----------------------------------------------------------------------------
// i2c master byte engine
// bit-banging i2c master: one request per time tick, one result per request
// ----------------------------------------------------------------------------
// Each request is one bus tick and yields exactly one result holding the
// driven scl/sda levels, busy, done, the last read byte and the nack flag.
// One request is taken every clock while full is low; the phase sequencer
// handles one tick per cycle while a tick is queued and the result queue has
// room, writing its result into that queue. When results are held back, the
// result queue fills first, then the tick queue, and only then does full rise;
// once the result queue has been full, a popped slot is refilled in the next
// cycle if a tick is queued. phase_ticks sets how many ticks each pin phase is
// held; write it only while no command is running.
module i2c_master_byte_engine
   import i2cm_pkg::*;
#(
   parameter int TICK_DEPTH = 2,
   parameter int RSP_DEPTH  = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_write_data,
   input  logic        req_send_ack,
   input  logic        req_sda_in,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_nack
);

   tick_type tick_push, tick_pop;
   rsp_type  rsp_push, rsp_head;
   logic     tick_empty;
   logic     rsp_full;
   logic     step;

   i2cm_front u_front (
      .action     (req_action),
      .write_data (req_write_data),
      .send_ack   (req_send_ack),
      .sda_in     (req_sda_in),
      .tick       (tick_push)
   );

   i2cm_fifo #(
      .WIDTH ($bits(tick_type)),
      .DEPTH (TICK_DEPTH)
   ) u_tick_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (tick_push),
      .full    (full),
      .rd_en   (step),
      .rd_data (tick_pop),
      .empty   (tick_empty)
   );

   // a tick is executed when one is queued and its result has room
   assign step = !tick_empty && !rsp_full;

   i2cm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step),
      .tick        (tick_pop),
      .rsp         (rsp_push)
   );

   i2cm_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (step),
      .wr_data (rsp_push),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_head),
      .empty   (empty)
   );

   assign rsp_scl_level = rsp_head.scl_level;
   assign rsp_sda_level = rsp_head.sda_level;
   assign rsp_busy_res  = rsp_head.busy_res;
   assign rsp_done_res  = rsp_head.done_res;
   assign rsp_read_byte = rsp_head.read_byte;
   assign rsp_nack      = rsp_head.nack;

endmodule

@@ sim/i2c_master_byte_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c master byte engine testbench
// pushes bus ticks through the request queue under random bursts and result
// stalls, predicts each tick's pin levels and status with a local model of the
// phase sequencer, and checks every popped result field by field
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_tb;
   import i2cm_pkg::*;

   localparam logic [2:0] ACT_RSVD6 = 3'd6;
   localparam logic [2:0] ACT_RSVD7 = 3'd7;

   // phase index of the sda release after the eight data bits
   localparam logic [4:0] WR_DATA_PHASES = 5'd24;
   localparam logic [4:0] RD_DATA_END    = 5'd18;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] write_data;
      logic       send_ack;
      logic       sda_in;
   } bus_tick_type;

   typedef struct packed {
      bus_tick_type tick;
      logic         keep_busy;
      logic         typed;
      rsp_type      want;
   } plan_row_type;

   localparam rsp_type LINES_HIGH_IDLE = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};

   // rows start at phase_ticks 3; unless keep_busy, the command runs to idle
   // with sda held at the row's level
   plan_row_type directed_plan [18] = '{
      '{'{ACT_NONE,    8'h00, 1'b0, 1'b1}, 1'b0, 1'b1, LINES_HIGH_IDLE},
      '{'{ACT_RSVD7,   8'hFF, 1'b1, 1'b1}, 1'b0, 1'b1, LINES_HIGH_IDLE},
      '{'{ACT_RSVD6,   8'h00, 1'b0, 1'b0}, 1'b0, 1'b1, LINES_HIGH_IDLE},
      '{'{ACT_RELEASE, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b1,
        '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{'{ACT_START,   8'h00, 1'b0, 1'b1}, 1'b0, 1'b1,
        '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{'{ACT_WRITE,   8'hFF, 1'b0, 1'b0}, 1'b0, 1'b1,
        '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{'{ACT_WRITE,   8'h00, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
      '{'{ACT_WRITE,   8'hA5, 1'b0, 1'b0}, 1'b1, 1'b0, '0},
      // read while the write is still running
      '{'{ACT_READ,    8'h00, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
      '{'{ACT_READ,    8'h00, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
      '{'{ACT_READ,    8'hFF, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{ACT_WRITE,   8'h5A, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
      '{'{ACT_READ,    8'h00, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
      '{'{ACT_STOP,    8'h00, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
      '{'{ACT_START,   8'h00, 1'b0, 1'b1}, 1'b1, 1'b0, '0},
      '{'{ACT_STOP,    8'h00, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
      '{'{ACT_RSVD7,   8'hFF, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
      '{'{ACT_RELEASE, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b0, '0}
   };

   logic [15:0]   random_setting [4] = '{16'd1, 16'd0, 16'd2, 16'd5};
   int unsigned   random_ticks   [4] = '{250, 150, 100, 100};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_action = ACT_NONE;
   logic [7:0]  req_write_data = 8'h00;
   logic        req_send_ack = 1'b0;
   logic        req_sda_in = 1'b1;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_byte;
   logic        rsp_nack;

   // bus model state
   logic [15:0] phase_len;
   logic        bus_scl;
   logic        bus_sda;
   logic [2:0]  run_op;
   logic [4:0]  phase_no;
   logic [15:0] held;
   logic [7:0]  shreg;
   logic        ack_sel;
   logic        nack_seen;
   logic [7:0]  last_read;

   rsp_type     pending_levels [$];
   int unsigned mismatches = 0;
   int unsigned burst_left = 0;

   logic [7:0]  pop_mask = 8'hFF;
   int unsigned pop_age = 0;

   i2c_master_byte_engine u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .push           (push),
      .full           (full),
      .req_action     (req_action),
      .req_write_data (req_write_data),
      .req_send_ack   (req_send_ack),
      .req_sda_in     (req_sda_in),
      .empty          (empty),
      .pop            (pop),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_nack       (rsp_nack)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic reset_bus_model();
      phase_len = PHASE_TICKS_RESET;
      bus_scl   = 1'b1;
      bus_sda   = 1'b1;
      run_op    = ACT_NONE;
      phase_no  = '0;
      held      = '0;
      shreg     = '0;
      ack_sel   = 1'b0;
      nack_seen = 1'b0;
      last_read = '0;
   endtask

   function automatic logic [4:0] phase_count(logic [2:0] op);
      case (op)
         ACT_RELEASE: return LAST_RELEASE + 5'd1;
         ACT_START:   return LAST_START + 5'd1;
         ACT_STOP:    return LAST_STOP + 5'd1;
         ACT_WRITE:   return LAST_WRITE + 5'd1;
         ACT_READ:    return LAST_READ + 5'd1;
         default:     return 5'd0;
      endcase
   endfunction

   // sda is taken at the end of the write ack clock and of each read clock high
   function automatic void sample_phase(logic [2:0] op, logic [4:0] idx, logic sda);
      if (op == ACT_WRITE && idx == WR_DATA_PHASES + 5'd1)
         nack_seen = sda;
      else if (op == ACT_READ && idx >= 5'd2 && idx < RD_DATA_END && !idx[0])
         shreg = {shreg[6:0], sda};
   endfunction

   function automatic void drive_phase(logic [2:0] op, logic [4:0] idx);
      case (op)
         ACT_RELEASE: begin
            if (idx == 5'd0) bus_scl = 1'b1;
            else bus_sda = 1'b1;
         end
         ACT_START: begin
            if (idx == 5'd0) bus_sda = 1'b0;
            else bus_scl = 1'b0;
         end
         ACT_STOP: begin
            if (idx == 5'd1) bus_scl = 1'b1;
            else bus_sda = (idx != 5'd0);
         end
         ACT_WRITE: begin
            if (idx < WR_DATA_PHASES) begin
               case (idx % 5'd3)
                  5'd0: bus_sda = shreg[7];
                  5'd1: bus_scl = 1'b1;
                  default: begin
                     bus_scl = 1'b0;
                     shreg = {shreg[6:0], 1'b0};
                  end
               endcase
            end else if (idx == WR_DATA_PHASES) begin
               bus_sda = 1'b1;
            end else if (idx == WR_DATA_PHASES + 5'd1) begin
               bus_scl = 1'b1;
            end else if (idx == WR_DATA_PHASES + 5'd2) begin
               bus_scl = 1'b0;
            end else begin
               bus_sda = 1'b0;
            end
         end
         ACT_READ: begin
            if (idx == 5'd0) begin
               bus_scl = 1'b0;
            end else if (idx == 5'd1) begin
               bus_sda = 1'b1;
            end else if (idx < RD_DATA_END) begin
               bus_scl = !idx[0];
            end else if (idx == RD_DATA_END) begin
               bus_sda = !ack_sel;
            end else if (idx == RD_DATA_END + 5'd1) begin
               bus_scl = 1'b1;
            end else if (idx == RD_DATA_END + 5'd2) begin
               bus_scl = 1'b0;
            end else begin
               bus_sda = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   // one bus tick of the sequencer; returns the levels and status it leaves
   function automatic rsp_type advance_bus_model(bus_tick_type t);
      logic [15:0] lim;
      logic        fin;
      rsp_type     r;
      lim = (phase_len == 16'd0) ? 16'd1 : phase_len;
      fin = 1'b0;
      if (run_op == ACT_NONE) begin
         if (t.action >= ACT_RELEASE && t.action <= ACT_READ) begin
            run_op   = t.action;
            phase_no = '0;
            held     = 16'd1;
            if (t.action == ACT_WRITE) shreg = t.write_data;
            if (t.action == ACT_READ) begin
               shreg   = '0;
               ack_sel = t.send_ack;
            end
            drive_phase(run_op, 5'd0);
         end
      end else if (held < lim) begin
         held = held + 16'd1;
      end else begin
         sample_phase(run_op, phase_no, t.sda_in);
         phase_no = phase_no + 5'd1;
         if (phase_no >= phase_count(run_op)) begin
            if (run_op == ACT_READ) last_read = shreg;
            run_op   = ACT_NONE;
            phase_no = '0;
            held     = '0;
            fin      = 1'b1;
         end else begin
            held = 16'd1;
            drive_phase(run_op, phase_no);
         end
      end
      r.scl_level = bus_scl;
      r.sda_level = bus_sda;
      r.busy_res  = (run_op != ACT_NONE);
      r.done_res  = fin;
      r.read_byte = last_read;
      r.nack      = nack_seen;
      return r;
   endfunction

   function automatic bus_tick_type quiet_tick(logic sda);
      bus_tick_type t;
      t.action     = ACT_NONE;
      t.write_data = 8'h00;
      t.send_ack   = 1'b0;
      t.sda_in     = sda;
      return t;
   endfunction

   function automatic bus_tick_type random_tick();
      bus_tick_type t;
      int unsigned  roll;
      roll = $urandom_range(0, 99);
      if (roll < 30)
         t.action = ACT_NONE;
      else if (roll < 38)
         t.action = ($urandom_range(0, 1) == 1) ? ACT_RSVD7 : ACT_RSVD6;
      else
         t.action = 3'($urandom_range(ACT_RELEASE, ACT_READ));
      t.write_data = 8'($urandom);
      t.send_ack   = 1'($urandom);
      t.sda_in     = 1'($urandom);
      return t;
   endfunction

   task automatic note_failure(string msg);
      $display("%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, int unsigned got, int unsigned want);
      if (got != want)
         note_failure($sformatf("%s mismatch: got %0h, want %0h", name, got, want));
   endtask

   task automatic send_tick(bus_tick_type t, logic typed, rsp_type want);
      int unsigned gap;
      rsp_type     predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_action     <= t.action;
      req_write_data <= t.write_data;
      req_send_ack   <= t.send_ack;
      req_sda_in     <= t.sda_in;
      push           <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      predicted = advance_bus_model(t);
      pending_levels.push_back(typed ? want : predicted);
   endtask

   // finish any running command, then let every result drain
   task automatic run_to_idle();
      while (run_op != ACT_NONE)
         send_tick(quiet_tick(1'($urandom)), 1'b0, '0);
      push <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_phase_ticks(logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      phase_len = value;
   endtask

   always @(posedge clock) begin
      if (pop_age == 0) begin
         pop_age  <= $urandom_range(20, 200);
         pop_mask <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h55);
      end else begin
         pop_age  <= pop_age - 1;
         pop_mask <= {pop_mask[0], pop_mask[7:1]};
      end
      pop <= pop_mask[0];
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (pending_levels.size() == 0) begin
            note_failure("result popped with no request pending");
         end else begin
            want = pending_levels.pop_front();
            check_field("scl_level", rsp_scl_level, want.scl_level);
            check_field("sda_level", rsp_sda_level, want.sda_level);
            check_field("busy_res", rsp_busy_res, want.busy_res);
            check_field("done_res", rsp_done_res, want.done_res);
            check_field("read_byte", rsp_read_byte, want.read_byte);
            check_field("nack", rsp_nack, want.nack);
         end
      end
   end

   initial begin
      bus_tick_type release_tick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      reset_bus_model();

      foreach (directed_plan[i]) begin
         send_tick(directed_plan[i].tick, directed_plan[i].typed, directed_plan[i].want);
         if (!directed_plan[i].keep_busy)
            while (run_op != ACT_NONE)
               send_tick(quiet_tick(directed_plan[i].tick.sda_in), 1'b0, '0);
      end
      run_to_idle();

      foreach (random_setting[p]) begin
         set_phase_ticks(random_setting[p]);
         repeat (random_ticks[p]) send_tick(random_tick(), 1'b0, '0);
         run_to_idle();
      end

      // long hold: a single release command
      set_phase_ticks(16'd64);
      release_tick = quiet_tick(1'b1);
      release_tick.action = ACT_RELEASE;
      send_tick(release_tick, 1'b0, '0);
      run_to_idle();

      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_levels.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
